>>> rtl/core/assert_macros.svh
// Assertion macros shared by the sparse matrix-vector core.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/csmr_pkg.sv
// Shared types and constants for the sparse matrix-vector row-reduce core.
// No dependencies; imported by every module of the core except csmr_ram.
`timescale 1ns / 1ps

package csmr_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
  localparam int ROW_BITS     = 16;
  localparam int ROW_KEEP     = (ROW_BITS < 16) ? ROW_BITS : 16;
  localparam logic [15:0] ROW_MASK = 16'((33'd1 << ROW_KEEP) - 33'd1);

  // Queue between front and back; depth must be a power of two.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [9:0]         col_index;
    logic [15:0]        row_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_row;
    logic signed [47:0] out_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               is_flush;
    logic [15:0]        row;
    logic signed [31:0] value;
    logic signed [31:0] vec;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

>>> rtl/core/csmr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module csmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/core/csmr_front.sv
// Front end: accepts input beats, writes or reads the vector store, and
// hands nonzero and flush items to the queue. Uses csmr_pkg and csmr_ram.
`timescale 1ns / 1ps

module csmr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  csmr_pkg::in_item_t   in_data,
  output logic                 in_stall,
  input  csmr_pkg::q_status_t  q_stat,
  output logic                 q_push,
  output csmr_pkg::q_entry_t   q_push_data
);
  import csmr_pkg::*;

  logic                 accept;
  logic                 col_ok;
  logic                 is_load;
  logic                 is_nz;
  logic                 is_flush;
  logic                 f1_adv;
  logic [31:0]          rd_data;
  logic [VEC_AW-1:0]    vec_addr;

  logic                 f1_valid_r;
  logic                 f1_valid_nxt;
  logic                 f1_flush_r;
  logic                 f1_col_ok_r;
  logic [15:0]          f1_row_r;
  logic signed [31:0]   f1_value_r;

  always_comb begin
    is_load  = 1'b0;
    is_nz    = 1'b0;
    is_flush = 1'b0;
    unique case (in_data.opcode)
      OP_LOAD:    is_load  = 1'b1;
      OP_NONZERO: is_nz    = 1'b1;
      OP_FLUSH:   is_flush = 1'b1;
      OP_RSVD:    ;
      default:    ;
    endcase
  end

  // The item in the holding stage can leave only when the queue has room.
  assign f1_adv   = !f1_valid_r || !q_stat.full;
  assign in_stall = f1_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign col_ok   = 32'(in_data.col_index) < 32'(VECTOR_DEPTH);
  assign vec_addr = VEC_AW'(in_data.col_index);

  csmr_ram #(
    .WIDTH(32),
    .DEPTH(VECTOR_DEPTH)
  ) u_vec_ram (
    .clk      (clk),
    .we       (accept && is_load && col_ok),
    .waddr    (vec_addr),
    .wdata    (in_data.value),
    .re       (accept && is_nz && col_ok),
    .raddr    (vec_addr),
    .rd_data_r(rd_data)
  );

  assign f1_valid_nxt = f1_adv ? (accept && (is_nz || is_flush)) : f1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv && accept) begin
      f1_flush_r  <= is_flush;
      f1_col_ok_r <= col_ok;
      f1_row_r    <= in_data.row_index & ROW_MASK;
      f1_value_r  <= in_data.value;
    end
  end

  // The read data stays put while the item waits, since no read is issued
  // while the input is stalled. A column beyond the store reads as zero.
  assign q_push               = f1_valid_r && !q_stat.full;
  assign q_push_data.is_flush = f1_flush_r;
  assign q_push_data.row      = f1_row_r;
  assign q_push_data.value    = f1_value_r;
  assign q_push_data.vec      = (f1_col_ok_r && !f1_flush_r) ? rd_data : '0;

endmodule

>>> rtl/core/csmr_queue.sv
// Short flip-flop queue between the front end and the arithmetic back end.
// Uses csmr_pkg.
`timescale 1ns / 1ps

module csmr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  csmr_pkg::q_entry_t   push_data,
  input  logic                 pop,
  output csmr_pkg::q_entry_t   head,
  output csmr_pkg::q_status_t  stat
);
  import csmr_pkg::*;

  q_entry_t          q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     cnt_r;
  logic [Q_AW:0]     cnt_nxt;

  assign stat.full     = cnt_r == (Q_AW + 1)'(Q_DEPTH);
  assign stat.nonempty = cnt_r != '0;
  assign head          = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/csmr_back.sv
// Back end: multiply, round, row accumulation with saturation, alpha scaling
// in two partial products, and the output register. Uses csmr_pkg.
`timescale 1ns / 1ps

module csmr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          alpha,
  input  csmr_pkg::q_entry_t   q_head,
  input  csmr_pkg::q_status_t  q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csmr_pkg::out_item_t  out_data
);
  import csmr_pkg::*;

  localparam logic signed [47:0] SUM_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;
  localparam logic [63:0] LIM_POS = 64'h0000_7fff_ffff_ffff;
  localparam logic [63:0] LIM_NEG = 64'h0000_8000_0000_0000;

  logic adv;

  // Multiply stage.
  logic               m_valid_r;
  logic               m_flush_r;
  logic [15:0]        m_row_r;
  logic signed [63:0] m_prod_r;
  logic signed [63:0] m_prod_nxt;

  // Rounding stage.
  logic               r_valid_r;
  logic               r_flush_r;
  logic [15:0]        r_row_r;
  logic signed [47:0] r_p_r;
  logic signed [63:0] rnd;

  // Row state.
  logic [15:0]        cur_row_r,  cur_row_nxt;
  logic signed [47:0] sum_r,      sum_nxt;
  logic               pend_r,     pend_nxt;
  logic               sat_seen_r, sat_seen_nxt;
  logic signed [48:0] sum_ext;
  logic signed [47:0] sum_clamp;
  logic               sum_ovf;

  // Finished row waiting for scaling.
  logic               e_valid_r,  e_valid_nxt;
  logic [15:0]        e_row_r;
  logic signed [47:0] e_sum_r;
  logic               e_sat_r;

  // Scaling stages.
  logic               s1_valid_r;
  logic [31:0]        s1_ma_r;
  logic [47:0]        s1_ms_r;
  logic               s1_neg_r;
  logic [15:0]        s1_row_r;
  logic               s1_sat_r;

  logic               s2_valid_r;
  logic [63:0]        s2_pl_r;
  logic [47:0]        s2_ph_r;
  logic               s2_neg_r;
  logic [15:0]        s2_row_r;
  logic               s2_sat_r;

  logic [63:0]        q_sum;
  logic               s3_neg;
  logic [63:0]        s3_lim;
  logic               s3_clamp;

  logic               s3_valid_r;
  logic [47:0]        s3_mag_r;
  logic               s3_neg_r;
  logic [15:0]        s3_row_r;
  logic               s3_sat_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  // The whole back end moves together; the output register is the skid.
  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && q_stat.nonempty;

  assign m_prod_nxt = 64'($signed(q_head.value)) * 64'($signed(q_head.vec));

  // Round to nearest, ties away from zero, on the signed product.
  assign rnd = m_prod_r + (m_prod_r[63] ? 64'sh7fff : 64'sh8000);

  assign sum_ext = {sum_r[47], sum_r} + {r_p_r[47], r_p_r};
  assign sum_ovf = sum_ext[48] != sum_ext[47];
  assign sum_clamp = !sum_ovf ? sum_ext[47:0] : (sum_ext[48] ? SUM_MIN : SUM_MAX);

  always_comb begin
    cur_row_nxt  = cur_row_r;
    sum_nxt      = sum_r;
    pend_nxt     = pend_r;
    sat_seen_nxt = sat_seen_r;
    e_valid_nxt  = 1'b0;
    if (r_valid_r && !r_flush_r) begin
      if (!pend_r || (r_row_r != cur_row_r)) begin
        // A row change closes the open row; the new row starts from this product.
        e_valid_nxt  = pend_r;
        cur_row_nxt  = r_row_r;
        sum_nxt      = r_p_r;
        sat_seen_nxt = 1'b0;
        pend_nxt     = 1'b1;
      end else begin
        sum_nxt      = sum_clamp;
        sat_seen_nxt = sat_seen_r || sum_ovf;
      end
    end else if (r_valid_r && r_flush_r) begin
      e_valid_nxt  = pend_r;
      pend_nxt     = 1'b0;
      sum_nxt      = '0;
      sat_seen_nxt = 1'b0;
    end
  end

  // Magnitude sum: upper partial product shifted in, lower one rounded.
  assign q_sum    = {s2_ph_r, 16'h0000} + ((s2_pl_r + 64'h8000) >> 16);
  assign s3_neg   = s2_neg_r && (q_sum != '0);
  assign s3_lim   = s3_neg ? LIM_NEG : LIM_POS;
  assign s3_clamp = q_sum > s3_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      r_valid_r   <= 1'b0;
      cur_row_r   <= '0;
      sum_r       <= '0;
      pend_r      <= 1'b0;
      sat_seen_r  <= 1'b0;
      e_valid_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r   <= q_pop;
      r_valid_r   <= m_valid_r;
      cur_row_r   <= cur_row_nxt;
      sum_r       <= sum_nxt;
      pend_r      <= pend_nxt;
      sat_seen_r  <= sat_seen_nxt;
      e_valid_r   <= e_valid_nxt;
      s1_valid_r  <= e_valid_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_flush_r <= q_head.is_flush;
      m_row_r   <= q_head.row;
      m_prod_r  <= m_prod_nxt;

      r_flush_r <= m_flush_r;
      r_row_r   <= m_row_r;
      r_p_r     <= rnd[63:16];

      e_row_r   <= cur_row_r;
      e_sum_r   <= sum_r;
      e_sat_r   <= sat_seen_r;

      s1_ma_r   <= alpha[31] ? (~alpha + 32'd1) : alpha;
      s1_ms_r   <= e_sum_r[47] ? (~e_sum_r + 48'd1) : e_sum_r;
      s1_neg_r  <= alpha[31] ^ e_sum_r[47];
      s1_row_r  <= e_row_r;
      s1_sat_r  <= e_sat_r;

      s2_pl_r   <= 64'(s1_ma_r) * 64'(s1_ms_r[31:0]);
      s2_ph_r   <= 48'(s1_ma_r) * 48'(s1_ms_r[47:32]);
      s2_neg_r  <= s1_neg_r;
      s2_row_r  <= s1_row_r;
      s2_sat_r  <= s1_sat_r;

      s3_mag_r  <= s3_clamp ? s3_lim[47:0] : q_sum[47:0];
      s3_neg_r  <= s3_neg;
      s3_row_r  <= s2_row_r;
      s3_sat_r  <= s2_sat_r || s3_clamp;

      out_data_r.out_row   <= s3_row_r;
      out_data_r.out_value <= s3_neg_r ? (~s3_mag_r + 48'd1) : s3_mag_r;
      out_data_r.saturated <= s3_sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/coo_sparse_matvec_row_reduce_core.sv
// Sparse matrix times dense vector, coordinate format, rows reduced on the fly.
// Top level; uses csmr_pkg, csmr_front, csmr_queue, csmr_back, assert_macros.svh.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one beat per
// item: load a vector entry, a matrix nonzero, or a flush. Nonzeros must come
// sorted by row. The output channel (out_valid, out_stall, out_data) carries one
// beat per finished row: its row number, alpha times the row sum in Q31.16, and
// a saturation flag. alpha_scale is written over the APB-style port at address 0
// and must only be changed while the block is idle.
// Throughput: one item per cycle unless out_stall holds the back end, set by the
// single multiply-accumulate on the running row sum. Once the beat that closes a
// row (next row's first nonzero or a flush) is accepted, its result passes the holding
// stage, queue, multiply, round, accumulate, three scaling stages and output register.
// When out_stall is high while a result waits, the whole back end holds; the
// four-entry queue and the holding stage in front of it keep taking beats until
// both are full, and then in_stall rises. Loads go straight to the vector store.
// Reset clears all control state and sets alpha_scale to 1.0. The vector store
// is not cleared: every entry must be loaded before a nonzero reads it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module coo_sparse_matvec_row_reduce_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csmr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csmr_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import csmr_pkg::*;

  logic        alpha_sign;
  logic [31:0] alpha_scale_r;
  logic        cfg_wr;

  logic        q_push;
  logic        q_pop;
  q_entry_t    q_push_data;
  q_entry_t    q_head;
  q_status_t   q_stat;

  // Only one register exists, so every address within the port maps to it.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[1:0] == 2'b00) ? alpha_scale_r : alpha_scale_r;
  assign alpha_sign = alpha_scale_r[31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_scale_r <= ALPHA_RESET;
    end else if (cfg_wr) begin
      alpha_scale_r <= pwdata;
    end
  end

  csmr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_push_data(q_push_data)
  );

  csmr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  csmr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .alpha    (alpha_scale_r),
    .q_head   (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The input only stalls when the queue has no room for the waiting item.
  `ASSERT_IMPL(a_stall_needs_full, in_stall, q_stat.full)
  // A full queue can never also read as empty.
  `ASSERT_ALWAYS(a_queue_count, !(q_stat.full && !q_stat.nonempty))
  // A configuration write lands in the scale register with its sign.
  `ASSERT_NEXT(a_alpha_write, cfg_wr, alpha_scale_r == $past(pwdata) && alpha_sign == $past(pwdata[31]))

endmodule

>>> test/tb_coo_sparse_matvec_row_reduce_core.sv
// Testbench for coo_sparse_matvec_row_reduce_core: loads, nonzeros and flushes go in,
// scaled row sums come out and are checked against a local row-sum predictor.
// Depends on csmr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_coo_sparse_matvec_row_reduce_core;
  import csmr_pkg::*;

  localparam logic [1:0] ALPHA_ADDR = 2'd0;
  localparam logic signed [48:0] SUM_MAX = 49'sh0_7fff_ffff_ffff;
  localparam logic signed [48:0] SUM_MIN = -SUM_MAX - 49'sd1;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 100;

  class row_sum_scoreboard;
    logic [31:0]        alpha;
    logic [31:0]        vec_store [VECTOR_DEPTH];
    logic [15:0]        open_row;
    logic signed [47:0] row_acc;
    bit                 row_open;
    bit                 acc_clamped;
    out_item_t          expected_rows [$];
    int                 errors;
    int                 rows_checked;
    int                 beats_in;

    function new();
      alpha = ALPHA_RESET;
      open_row = '0;
      row_acc = '0;
      row_open = 0;
      acc_clamped = 0;
      errors = 0;
      rows_checked = 0;
      beats_in = 0;
    endfunction

    // Q15.16 times Q15.16, rounded half away from zero to Q31.16.
    function logic signed [47:0] q16_product(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      p = ({32'd0, ma} * {32'd0, mb} + 64'h8000) >> 16;
      return (a[31] ^ b[31]) ? -p[47:0] : p[47:0];
    endfunction

    // Scales the open row by alpha and closes it.
    function out_item_t close_row();
      logic [31:0] alpha_mag;
      logic [47:0] sum_mag;
      logic [79:0] q;
      logic        neg;
      logic        clamp;
      out_item_t   r;
      alpha_mag = alpha[31] ? -alpha : alpha;
      sum_mag = row_acc[47] ? -row_acc : row_acc;
      q = ({48'd0, alpha_mag} * {32'd0, sum_mag} + 80'h8000) >> 16;
      neg = (alpha[31] != row_acc[47]) && (q != 80'd0);
      clamp = 1'b0;
      if (neg && q > 80'h8000_0000_0000) begin
        q = 80'h8000_0000_0000;
        clamp = 1'b1;
      end else if (!neg && q > 80'h7fff_ffff_ffff) begin
        q = 80'h7fff_ffff_ffff;
        clamp = 1'b1;
      end
      r.out_row = open_row;
      r.out_value = neg ? -q[47:0] : q[47:0];
      r.saturated = clamp | acc_clamped;
      row_acc = '0;
      acc_clamped = 0;
      row_open = 0;
      return r;
    endfunction

    function void note_input(in_item_t it);
      logic signed [47:0] prod;
      logic signed [48:0] s;
      logic [15:0]        row;
      beats_in++;
      case (it.opcode)
        OP_LOAD: begin
          vec_store[it.col_index] = it.value;
        end
        OP_NONZERO: begin
          prod = q16_product(it.value, vec_store[it.col_index]);
          row = it.row_index & ROW_MASK;
          if (row_open && row != open_row) expected_rows.push_back(close_row());
          if (!row_open) begin
            open_row = row;
            row_acc = '0;
            acc_clamped = 0;
            row_open = 1;
          end
          s = 49'(row_acc) + 49'(prod);
          if (s > SUM_MAX) begin
            s = SUM_MAX;
            acc_clamped = 1;
          end else if (s < SUM_MIN) begin
            s = SUM_MIN;
            acc_clamped = 1;
          end
          row_acc = s[47:0];
        end
        OP_FLUSH: begin
          if (row_open) expected_rows.push_back(close_row());
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      string     diffs;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d value %h sat %0d",
                                  got.out_row, got.out_value, got.saturated));
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      diffs = "";
      if (got.out_row !== want.out_row)
        diffs = {diffs, $sformatf(" row %0d/%0d", got.out_row, want.out_row)};
      if (got.out_value !== want.out_value)
        diffs = {diffs, $sformatf(" value %h/%h", got.out_value, want.out_value)};
      if (got.saturated !== want.saturated)
        diffs = {diffs, $sformatf(" sat %0d/%0d", got.saturated, want.saturated)};
      if (diffs != "") report_mismatch({"result got/expected:", diffs});
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  row_sum_scoreboard sb;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  bit          hold_taken;
  int          hold_left;
  bit          vec_loaded [VECTOR_DEPTH];
  logic [9:0]  loaded_cols [$];
  logic [15:0] cur_row;
  int          alpha_settings;

  coo_sparse_matvec_row_reduce_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("coo_sparse_matvec_row_reduce_core verification failed");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off when requested.
  initial begin
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(it);
  endtask

  task send_op(opcode_t op, logic [9:0] col, logic [15:0] row, logic [31:0] val);
    in_item_t it;
    it.opcode = op;
    it.col_index = col;
    it.row_index = row;
    it.value = val;
    if (op == OP_LOAD && !vec_loaded[col]) begin
      vec_loaded[col] = 1;
      loaded_cols.push_back(col);
    end
    send_item(it);
  endtask

  task write_alpha(logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ALPHA_ADDR;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    sb.alpha = val;
    alpha_settings++;
    // Read the register back in a second transfer.
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (prdata !== val)
      sb.report_mismatch($sformatf("alpha readback %h, wrote %h", prdata, val));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // The last beat was taken at the previous rising edge, so the input goes idle
  // before anything else happens.
  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] random_value();
    logic [31:0] v;
    int          r;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(4))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        3: v = 32'h0001_0000;
        default: v = 32'hffff_0000;
      endcase
    end else if (r < 70) begin
      // Small magnitudes keep most row sums clear of the clamp.
      v = $urandom_range(32'h0008_0000);
      v = v - 32'h0004_0000;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task send_random_items(int count);
    int sent;
    int roll;
    int r;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (loaded_cols.size() == 0 || roll < 12) begin
        send_op(OP_LOAD, 10'($urandom_range(VECTOR_DEPTH - 1)), 16'($urandom),
                random_value());
        sent++;
      end else if (roll < 86) begin
        // Mostly sorted rows; occasional jumps and a backward step.
        r = $urandom_range(99);
        if (r >= 95) cur_row = cur_row - 16'd1;
        else if (r >= 85) cur_row = 16'($urandom);
        else if (r >= 55) cur_row = cur_row + 16'd1;
        send_op(OP_NONZERO, loaded_cols[$urandom_range(loaded_cols.size() - 1)],
                cur_row, random_value());
        sent++;
      end else if (roll < 95) begin
        send_op(OP_FLUSH, 10'($urandom), 16'($urandom), $urandom);
        sent++;
      end else begin
        send_op(OP_RSVD, 10'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  task send_directed();
    send_op(OP_FLUSH, 10'd3, 16'h1234, 32'h0000_0001);
    send_op(OP_RSVD, 10'h3ff, 16'hffff, 32'hffff_ffff);
    send_op(OP_LOAD, 10'd0, 16'h0000, 32'h8000_0000);
    send_op(OP_LOAD, 10'h3ff, 16'hffff, 32'h7fff_ffff);
    send_op(OP_LOAD, 10'd5, 16'h0000, 32'h0001_8000);
    send_op(OP_LOAD, 10'd6, 16'h0000, 32'hffff_8000);
    send_op(OP_NONZERO, 10'd5, 16'h0000, 32'h0001_0000);
    // One LSB times -0.5 lands exactly on a rounding tie.
    send_op(OP_NONZERO, 10'd6, 16'h0000, 32'h0000_0001);
    send_op(OP_NONZERO, 10'd0, 16'hffff, 32'h8000_0000);
    send_op(OP_NONZERO, 10'd0, 16'hffff, 32'h8000_0000);
    send_op(OP_NONZERO, 10'h3ff, 16'hffff, 32'h7fff_ffff);
    send_op(OP_RSVD, 10'd0, 16'h0000, 32'h0000_0000);
    send_op(OP_FLUSH, 10'd0, 16'h0000, 32'h0000_0000);
    send_op(OP_FLUSH, 10'h3ff, 16'hffff, 32'hffff_ffff);
    repeat (3) send_op(OP_NONZERO, 10'd0, 16'd9, 32'h7fff_ffff);
    send_op(OP_NONZERO, 10'h3ff, 16'd3, 32'h8000_0000);
    send_op(OP_NONZERO, 10'd0, 16'd3, 32'h7fff_ffff);
    // Overwrite a vector entry while a row is still open.
    send_op(OP_LOAD, 10'd5, 16'hffff, 32'h0000_0000);
    send_op(OP_NONZERO, 10'd5, 16'd3, 32'h7fff_ffff);
    send_op(OP_NONZERO, 10'd6, 16'd2, 32'hffff_ffff);
    send_op(OP_FLUSH, 10'd0, 16'd0, 32'h0000_0000);
  endtask

  initial begin
    logic [31:0] alphas [6];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    cur_row = '0;
    alpha_settings = 1;
    send_idle_pct = 25;
    recv_stall_pct = 56;
    alphas[0] = 32'h7fff_ffff;
    alphas[1] = 32'h8000_0000;
    alphas[2] = 32'hffff_0000;
    alphas[3] = 32'h0000_0000;
    alphas[4] = 32'h0000_8000;
    alphas[5] = $urandom;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_directed();

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_alpha(alphas[p]);
      if (p < 2) begin
        send_idle_pct = 25;
        recv_stall_pct = 56;
      end else if (p < 4) begin
        send_idle_pct = 56;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // Freeze the result side while beats keep coming, so the queue backs up.
      if (p == 4) hold_req = 1'b1;
      send_random_items(PHASE_ITEMS);
      send_op(OP_FLUSH, 10'($urandom), 16'($urandom), $urandom);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_drained();
    $display("Run covered %0d input beats and %0d checked row results under %0d alpha settings,",
             sb.beats_in, sb.rows_checked, alpha_settings);
    $display("with idle and stall mixes on both sides and one long result hold-off.");
    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("coo_sparse_matvec_row_reduce_core verification clean");
    end else begin
      $display("coo_sparse_matvec_row_reduce_core verification failed");
    end
    $finish;
  end

endmodule
